### rtl/smf_pkg.sv
// Shared types and constants of the switching median filter.
package smf_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  // Window half size comes from a 3-bit register, so it never exceeds 3.
  localparam int HALF_W    = 2;
  localparam int HALF_TOP  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_WIN    = 3'd2,
    CFG_LOW    = 3'd3,
    CFG_HIGH   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CEN    = 8'b0000_0010,
    ST_CENW   = 8'b0000_0100,
    ST_GATHER = 8'b0000_1000,
    ST_LAST   = 8'b0001_0000,
    ST_MSTART = 8'b0010_0000,
    ST_MWAIT  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  // Control from the sequencer to the median selector.
  typedef struct packed {
    logic             load;
    logic             start;
    logic [PIX_W-1:0] data;
  } sel_ctrl_t;

  // Status back from the median selector.
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } sel_stat_t;

endpackage

### rtl/smf_in_if.sv
// Input channel: pixel or flush beats.
interface smf_in_if import smf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, action, pixel_in, input ready);
  modport sink   (input valid, action, pixel_in, output ready);
endinterface

### rtl/smf_out_if.sv
// Output channel: filtered pixel beats.
interface smf_out_if import smf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

### rtl/switching_median_filter.sv
// Switching median filter: top level with sequencer, counters and registers.
// Pixels enter in raster order and leave in raster order after a delay of
// h*W+h pixels (h = half window); flush beats after the frame release the
// held results. A pixel outside the thresholds is replaced by the median of
// its window: the n window pixels are read one per cycle through the single
// read port of the line store, and the median is found one bit per cycle by
// a bit-serial rank selection, twice for even counts.
// A held output beat that is not taken stretches the output cycle.
// A new beat is taken while a finished result still waits at the output.
// No clearing pass follows reset.
module switching_median_filter import smf_pkg::*; #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  smf_in_if.sink               in_i,
  smf_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int RING_ROWS = MAX_WINDOW + 1;
  localparam int RW        = $clog2(RING_ROWS);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int HMAX      = (MAX_WINDOW - 1) / 2;
  localparam int HCAP      = (HMAX < HALF_TOP) ? HMAX : HALF_TOP;
  localparam int WN        = MAX_WINDOW * MAX_WINDOW;
  localparam int NW        = $clog2(WN + 1);
  localparam int DMAX      = HCAP * MAX_WIDTH + HCAP;
  localparam int PW        = $clog2(DMAX + 2);

  state_e state_q, state_d;

  // Configuration registers
  logic [10:0]      width_q;
  logic [15:0]      height_q;
  logic [2:0]       wsize_q;
  logic [PIX_W-1:0] low_q, high_q;
  logic             cfg_hit;

  // Frame counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [15:0]   in_row_q, out_row_q;
  logic [RW-1:0] in_ring_q, out_ring_q;
  logic [PW-1:0] pend_q;

  // Window walk
  logic [15:0]   g_row_q, g_r1_q;
  logic [RW-1:0] g_ring_q;
  logic [CW-1:0] g_col_q, g_c0_q, g_c1_q;
  logic [NW-1:0] n_q;
  logic          ld_q;

  logic [PIX_W-1:0] res_q, out_pix_q;
  logic             out_vld_q, out_last_q;

  // Effective geometry
  logic [WW-1:0]     eff_w;
  logic [15:0]       eff_h;
  logic [HALF_W-1:0] half, half_raw, up;
  logic [PW-1:0]     lag;

  logic             in_fire, is_pix, frame_in_done, out_open, gather_end, last;
  logic             mem_we, mem_re, noisy;
  logic [AW-1:0]    waddr, raddr;
  logic [PIX_W-1:0] rdata;
  logic [16:0]      rsum;
  logic [WW:0]      csum;
  logic [RW:0]      ring_wrap;
  logic [15:0]      r0;
  logic [RW-1:0]    ring0;
  logic [CW-1:0]    c0, c1;
  logic [15:0]      r1;
  sel_ctrl_t        sel_ctrl;
  sel_stat_t        sel_stat;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] ring,
                                            input logic [CW-1:0] col);
    addr_of = AW'(ring) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  // Clamp width, height and half window
  always_comb begin
    if (width_q == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    eff_h    = (height_q == 16'd0) ? 16'd1 : height_q;
    half_raw = wsize_q[2:1];
    half     = (32'({half_raw, 1'b1}) > MAX_WINDOW) ? HALF_W'(HMAX) : half_raw;
  end

  assign lag = PW'(half) * PW'(eff_w) + PW'(half);

  // Configuration writes
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CFG_HIGH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 16'd480;
      wsize_q  <= 3'd3;
      low_q    <= 8'd20;
      high_q   <= 8'd220;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_WIN:    wsize_q  <= cfg_data_i[2:0];
        CFG_LOW:    low_q    <= cfg_data_i[PIX_W-1:0];
        CFG_HIGH:   high_q   <= cfg_data_i[PIX_W-1:0];
        default:    ;
      endcase
    end
  end

  // Beat decode
  assign in_fire       = in_i.valid && in_i.ready;
  assign frame_in_done = (in_row_q >= eff_h);
  assign is_pix        = (in_i.action == ACT_PIXEL) && !frame_in_done;
  assign out_open      = !out_vld_q || out_o.ready;
  assign gather_end    = (g_col_q == g_c1_q) && (g_row_q == g_r1_q);
  assign last          = (({1'b0, out_row_q} + 17'd1) >= {1'b0, eff_h})
                      && ((WW'(out_col_q) + 1'b1) >= eff_w);
  assign noisy         = (rdata < low_q) || (rdata > high_q);

  // Window bounds around the output pixel, clipped to the image
  always_comb begin
    up        = (out_row_q >= 16'(half)) ? half : HALF_W'(out_row_q);
    r0        = out_row_q - 16'(up);
    ring_wrap = {1'b0, out_ring_q} + (RW+1)'(RING_ROWS) - (RW+1)'(up);
    ring0     = (out_ring_q >= RW'(up)) ? out_ring_q - RW'(up) : RW'(ring_wrap);
    rsum      = {1'b0, out_row_q} + 17'(half);
    r1        = (rsum < {1'b0, eff_h}) ? rsum[15:0] : eff_h - 16'd1;
    c0        = (out_col_q >= CW'(half)) ? out_col_q - CW'(half) : '0;
    csum      = (WW+1)'(out_col_q) + (WW+1)'(half);
    c1        = (csum < {1'b0, eff_w}) ? CW'(csum) : CW'(eff_w - 1'b1);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_pix) begin
            if (pend_q >= lag) begin
              state_d = ST_CEN;
            end
          end else if (frame_in_done && (out_row_q < eff_h)) begin
            state_d = ST_CEN;
          end
        end
      end
      ST_CEN:    state_d = ST_CENW;
      ST_CENW:   state_d = noisy ? ST_GATHER : ST_OUT;
      ST_GATHER: state_d = gather_end ? ST_LAST : ST_GATHER;
      ST_LAST:   state_d = ST_MSTART;
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT:  state_d = sel_stat.done ? ST_OUT : ST_MWAIT;
      ST_OUT:    state_d = out_open ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Line store ports
  assign mem_we = (state_q == ST_IDLE) && in_fire && is_pix;
  assign waddr  = addr_of(in_ring_q, in_col_q);
  assign mem_re = (state_q == ST_CEN) || (state_q == ST_GATHER);
  assign raddr  = (state_q == ST_CEN) ? addr_of(out_ring_q, out_col_q)
                                      : addr_of(g_ring_q, g_col_q);

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      pend_q     <= '0;
      ld_q       <= 1'b0;
      n_q        <= '0;
      out_vld_q  <= 1'b0;
      out_pix_q  <= '0;
      out_last_q <= 1'b0;
      res_q      <= '0;
      g_row_q    <= '0;
      g_ring_q   <= '0;
      g_col_q    <= '0;
      g_c0_q     <= '0;
      g_c1_q     <= '0;
      g_r1_q     <= '0;
    end else begin
      state_q <= state_d;
      ld_q    <= (state_q == ST_GATHER);
      if (ld_q) begin
        n_q <= n_q + 1'b1;
      end
      // Taken beat leaves unless the output cycle loads a new one
      if (out_o.ready && !((state_q == ST_OUT) && !cfg_hit)) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_hit) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
        pend_q     <= '0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_fire && is_pix) begin
              if ((WW'(in_col_q) + 1'b1) >= eff_w) begin
                in_col_q  <= '0;
                in_row_q  <= in_row_q + 16'd1;
                in_ring_q <= (in_ring_q == RW'(RING_ROWS - 1)) ? '0
                                                               : in_ring_q + 1'b1;
              end else begin
                in_col_q <= in_col_q + 1'b1;
              end
              if (pend_q < lag) begin
                pend_q <= pend_q + 1'b1;
              end
            end else if (in_fire && frame_in_done && (out_row_q < eff_h)) begin
              pend_q <= pend_q - 1'b1;
            end
          end
          ST_CENW: begin
            res_q    <= rdata;
            g_row_q  <= r0;
            g_ring_q <= ring0;
            g_col_q  <= c0;
            g_c0_q   <= c0;
            g_c1_q   <= c1;
            g_r1_q   <= r1;
            n_q      <= '0;
          end
          ST_GATHER: begin
            if (g_col_q == g_c1_q) begin
              g_col_q <= g_c0_q;
              if (g_row_q != g_r1_q) begin
                g_row_q  <= g_row_q + 16'd1;
                g_ring_q <= (g_ring_q == RW'(RING_ROWS - 1)) ? '0 : g_ring_q + 1'b1;
              end
            end else begin
              g_col_q <= g_col_q + 1'b1;
            end
          end
          ST_MWAIT: begin
            if (sel_stat.done) begin
              res_q <= sel_stat.value;
            end
          end
          ST_OUT: begin
            if (out_open) begin
              out_vld_q  <= 1'b1;
              out_pix_q  <= res_q;
              out_last_q <= last;
              if (last) begin
                in_col_q   <= '0;
                in_row_q   <= '0;
                in_ring_q  <= '0;
                out_col_q  <= '0;
                out_row_q  <= '0;
                out_ring_q <= '0;
                pend_q     <= '0;
              end else if ((WW'(out_col_q) + 1'b1) >= eff_w) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + 16'd1;
                out_ring_q <= (out_ring_q == RW'(RING_ROWS - 1)) ? '0
                                                                 : out_ring_q + 1'b1;
              end else begin
                out_col_q <= out_col_q + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Selector control
  assign sel_ctrl.load  = ld_q;
  assign sel_ctrl.start = (state_q == ST_MSTART);
  assign sel_ctrl.data  = rdata;

  smf_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_i.pixel_in),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  smf_select #(
    .WN (WN),
    .NW (NW)
  ) u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sel_ctrl),
    .n_i    (n_q),
    .stat_o (sel_stat)
  );

  // Channel outputs
  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.frame_last = out_last_q;

`ifndef NO_ASSERTIONS
  // Held results never exceed the output delay
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= lag) else $error("pending count above delay");

  // Line store is written only from the idle state
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE)) else $error("line store write while busy");

  // A median is started only over a non-empty window
  a_start_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_ctrl.start |-> (n_q != '0)) else $error("median start on empty window");
`endif

endmodule

### rtl/smf_line_mem.sv
// Line store: ring of image rows, one write and one registered read port.
module smf_line_mem import smf_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/smf_select.sv
// Window shift register and bit-serial median selection (radix select).
module smf_select import smf_pkg::*; #(
  parameter int WN = 49,
  parameter int NW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sel_ctrl_t     ctrl_i,
  input  logic [NW-1:0] n_i,
  output sel_stat_t     stat_o
);

  logic [PIX_W-1:0] win_q [WN];
  logic [WN-1:0]    alive_q, mask, zero_bits, one_bits;
  logic [NW-1:0]    k_q, zeros, kbase;
  logic [2:0]       bit_q;
  logic [PIX_W-1:0] cur_q, first_q, res_q, val;
  logic             busy_q, done_q, even_q, second_q, take_one, finish;
  logic [PIX_W:0]   sum;

  // Window values shift in, newest at entry 0
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = WN - 1; i > 0; i--) begin
        win_q[i] <= win_q[i-1];
      end
      win_q[0] <= ctrl_i.data;
    end
  end

  // Candidate masks for the current bit plane
  always_comb begin
    for (int i = 0; i < WN; i++) begin
      mask[i]      = (NW'(i) < n_i);
      zero_bits[i] = alive_q[i] & ~win_q[i][bit_q];
      one_bits[i]  = alive_q[i] & win_q[i][bit_q];
    end
  end

  assign zeros    = NW'($countones(zero_bits));
  assign kbase    = NW'((n_i - 1'b1) >> 1);
  assign take_one = (k_q >= zeros);
  assign val      = {cur_q[PIX_W-2:0], take_one};
  assign sum      = {1'b0, first_q} + {1'b0, val};
  // Last bit of the last pass
  assign finish   = busy_q && !ctrl_i.start && (bit_q == 3'd0) && !second_q;

  // One bit of the selected rank per cycle, MSB first; even counts run twice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      alive_q  <= '0;
      k_q      <= '0;
      bit_q    <= '0;
      cur_q    <= '0;
      first_q  <= '0;
      res_q    <= '0;
      even_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      done_q <= finish;
      if (ctrl_i.start) begin
        busy_q   <= 1'b1;
        alive_q  <= mask;
        k_q      <= kbase;
        bit_q    <= 3'd7;
        even_q   <= ~n_i[0];
        second_q <= ~n_i[0];
      end else if (busy_q) begin
        cur_q <= val;
        if (bit_q != 3'd0) begin
          alive_q <= take_one ? one_bits : zero_bits;
          if (take_one) begin
            k_q <= k_q - zeros;
          end
          bit_q <= bit_q - 3'd1;
        end else if (second_q) begin
          first_q  <= val;
          second_q <= 1'b0;
          alive_q  <= mask;
          k_q      <= kbase + 1'b1;
          bit_q    <= 3'd7;
        end else begin
          busy_q <= 1'b0;
          res_q  <= even_q ? sum[PIX_W:1] : val;
        end
      end
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.value = res_q;

endmodule

### tb/sv/tb_switching_median_filter.sv
// Testbench of the switching median filter: scoreboard with a pixel-level predictor.
module tb_switching_median_filter;
  import smf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index past the end of the register list: a write must do nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
  localparam int RING   = 8;
  localparam int MAXW   = 1024;
  localparam int SETTLE = 200;

  // Scoreboard: keeps a copy of the line store and counters and queues the
  // pixels the block must produce
  class smf_scoreboard;
    bit [10:0] width;
    bit [15:0] height;
    bit [2:0]  win;
    bit [7:0]  lo_thr, hi_thr;
    bit [7:0]  rows [RING*MAXW];
    int unsigned in_col, in_row, out_col, out_row;
    bit [8:0]  pending [$];
    int        errors;

    function new();
      width = 640; height = 480; win = 3; lo_thr = 20; hi_thr = 220;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      errors = 0;
    endfunction

    function int unsigned w_eff();
      if (width == 0) return 1;
      if (width > MAXW) return MAXW;
      return width;
    endfunction

    function int unsigned h_eff();
      return (height == 0) ? 1 : height;
    endfunction

    function int unsigned half();
      return win / 2;
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_WIDTH:  width  = v[10:0];
        CFG_HEIGHT: height = v[15:0];
        CFG_WIN:    win    = v[2:0];
        CFG_LOW:    lo_thr = v[7:0];
        CFG_HIGH:   hi_thr = v[7:0];
        default:    return;
      endcase
      restart();
    endfunction

    function bit [7:0] px_at(int unsigned r, int unsigned c);
      return rows[(r % RING) * MAXW + (c % MAXW)];
    endfunction

    // Produce the pixel at the output position, median if it looks like noise
    function void release_pixel();
      int unsigned wd, ht, hh, r, c, r0, r1, c0, c1, n, val;
      bit [7:0] vals [$];
      bit last;
      wd = w_eff(); ht = h_eff(); hh = half();
      r = out_row; c = out_col;
      val = px_at(r, c);
      last = (r + 1 >= ht) && (c + 1 >= wd);
      if (val < lo_thr || val > hi_thr) begin
        r0 = (r >= hh) ? r - hh : 0;
        r1 = (r + hh < ht) ? r + hh : ht - 1;
        c0 = (c >= hh) ? c - hh : 0;
        c1 = (c + hh < wd) ? c + hh : wd - 1;
        for (int unsigned i = r0; i <= r1; i++)
          for (int unsigned j = c0; j <= c1; j++)
            vals.push_back(px_at(i, j));
        vals.sort();
        n = vals.size();
        if (n[0] == 1'b0) val = (int'(vals[n/2-1]) + int'(vals[n/2])) >> 1;
        else val = vals[n/2];
      end
      pending.push_back({last, val[7:0]});
      if (last) begin
        restart();
      end else if (c + 1 >= wd) begin
        out_col = 0;
        out_row = r + 1;
      end else begin
        out_col = c + 1;
      end
    endfunction

    // Accepted input beat
    function void note_beat(logic act, logic [7:0] px);
      longint unsigned p, q, d;
      int unsigned wd, ht, hh;
      wd = w_eff(); ht = h_eff(); hh = half();
      if (act == ACT_PIXEL && in_row < ht) begin
        p = longint'(in_row) * wd + in_col;
        q = longint'(out_row) * wd + out_col;
        d = longint'(hh) * wd + hh;
        rows[(in_row % RING) * MAXW + (in_col % MAXW)] = px;
        if (in_col + 1 >= wd) begin
          in_col = 0;
          in_row++;
        end else begin
          in_col++;
        end
        if (p >= q + d) release_pixel();
        return;
      end
      if (in_row >= ht && out_row < ht) release_pixel();
    endfunction

    // Accepted output beat
    function void check_beat(logic [7:0] px, logic last);
      bit [8:0] exp_beat;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat pixel=%0d last=%0b", px, last);
        return;
      end
      exp_beat = pending.pop_front();
      if (px !== exp_beat[7:0] || last !== exp_beat[8]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                   exp_beat[7:0], exp_beat[8], px, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  smf_in_if  in_if ();
  smf_out_if out_if ();

  switching_median_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  smf_scoreboard sb = new();
  int  taken = 0;
  int  sent = 0;
  bit  jitter = 1'b1;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Monitor: check results first, then note the accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.pixel_out, out_if.frame_last);
      if (in_if.valid && in_if.ready) begin
        sb.note_beat(in_if.action, in_if.pixel_in);
        taken++;
      end
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (jitter && !quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("[switching_median_filter] ERROR");
    $finish;
  end

  task automatic put_beat(logic act, logic [7:0] px);
    int seen;
    int gap;
    if (jitter && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seen = taken;
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.pixel_in <= px;
    do @(negedge clk_i); while (taken == seen);
    sent++;
  endtask

  // Wait for every expected pixel, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic setup(int w, int ht, int wn, int lo, int hi);
    put_reg(CFG_WIDTH,  {5'($urandom), 11'(w)});
    put_reg(CFG_HEIGHT, 16'(ht));
    put_reg(CFG_WIN,    {13'($urandom), 3'(wn)});
    put_reg(CFG_LOW,    {8'($urandom), 8'(lo)});
    put_reg(CFG_HIGH,   {8'($urandom), 8'(hi)});
  endtask

  function automatic logic [7:0] noisy_pixel();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1: return 8'($urandom_range(0, 15));
      2: return 8'($urandom_range(240, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame: all pixels, then flush beats; a frame of more than cap pixels gets only cap pixels
  task automatic frame(int cap);
    int unsigned npx, dly;
    npx = sb.w_eff() * sb.h_eff();
    dly = sb.half() * sb.w_eff() + sb.half();
    if (npx > cap) begin
      repeat (cap) put_beat(ACT_PIXEL, noisy_pixel());
    end else begin
      repeat (npx) begin
        // stray flush inside the frame does nothing
        if ($urandom_range(0, 19) == 0) put_beat(ACT_FLUSH, 8'($urandom));
        put_beat(ACT_PIXEL, noisy_pixel());
      end
      repeat (dly) begin
        // pixel while results are pending is dropped and acts as a flush
        if ($urandom_range(0, 6) == 0) put_beat(ACT_PIXEL, 8'($urandom));
        else put_beat(ACT_FLUSH, 8'($urandom));
      end
      repeat ($urandom_range(0, 2)) put_beat(ACT_FLUSH, 8'($urandom));
    end
    drain();
  endtask

  initial begin
    int w, ht, lo, hi;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_PIXEL;
    in_if.pixel_in = '0;
    out_if.ready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: 3x3 frame with values at and around the thresholds
    setup(3, 3, 3, 20, 220);
    put_reg(CFG_SPARE, 16'hffff);
    put_beat(ACT_PIXEL, 8'd0);
    put_beat(ACT_PIXEL, 8'd255);
    put_beat(ACT_PIXEL, 8'd20);
    put_beat(ACT_PIXEL, 8'd19);
    put_beat(ACT_FLUSH, 8'd77);
    put_beat(ACT_PIXEL, 8'd220);
    put_beat(ACT_PIXEL, 8'd221);
    put_beat(ACT_PIXEL, 8'd128);
    put_beat(ACT_PIXEL, 8'd21);
    put_beat(ACT_PIXEL, 8'd219);
    put_beat(ACT_PIXEL, 8'd5);
    repeat (4) put_beat(ACT_FLUSH, 8'd0);
    put_beat(ACT_FLUSH, 8'd0);
    drain();
    // Zero width and height, window zero, crossed thresholds
    setup(0, 0, 0, 200, 50);
    put_beat(ACT_PIXEL, 8'd100);
    put_beat(ACT_PIXEL, 8'd255);
    drain();
    // Widest row and tallest frame, aborted by the next register write
    setup(2047, 65535, 7, 255, 0);
    frame(6);
    setup(1, 65535, 6, 0, 255);
    frame(8);
    setup(1024, 1, 1, 128, 128);
    frame(12);

    // Random frames, mostly small
    while (sent < 1300) begin
      jitter = ($urandom_range(0, 9) < 7);
      quiet  = (sent > 1100);
      lo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(5, 60);
      hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(190, 250);
      if ($urandom_range(0, 14) == 0) begin
        w = $urandom_range(1000, 2047);
        ht = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(0, 12);
        ht = $urandom_range(0, 8);
      end
      setup(w, ht, $urandom_range(0, 7), lo, hi);
      frame(60);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[switching_median_filter] OK");
    end else begin
      $display("[switching_median_filter] ERROR");
    end
    $finish;
  end

endmodule
